/* rtl/iebam_pkg.sv */
// Shared types and codes for the I2C EEPROM byte access master.
package iebam_pkg;

    localparam logic [1:0] ACT_PLAIN = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic REG_DEV_ADDR = 1'b0;
    localparam logic REG_ACK_TMO  = 1'b1;

    localparam logic [6:0] DEV_ADDR_RST = 7'd80;
    localparam logic [7:0] ACK_TMO_RST  = 8'd255;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_START1 = 4'd1,
        ST_CTRLW  = 4'd2,
        ST_ACK1   = 4'd3,
        ST_ADDR   = 4'd4,
        ST_ACK2   = 4'd5,
        ST_DATA   = 4'd6,
        ST_ACK3   = 4'd7,
        ST_START2 = 4'd8,
        ST_CTRLR  = 4'd9,
        ST_ACK4   = 4'd10,
        ST_READ   = 4'd11,
        ST_STOP   = 4'd12
    } t_stage;

    typedef struct packed {
        t_stage     stage;
        logic [1:0] sub;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [8:0] poll_count;
        logic       is_read;
        logic [7:0] held_address;
        logic [7:0] held_data;
        logic       scl;
        logic       sda;
    } t_state;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_result;

endpackage

/* rtl/iebam_regs.sv */
// APB configuration registers: device address and ACK timeout.
module iebam_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output iebam_pkg::t_cfg     o_cfg
);

    logic [6:0] r_dev_addr;
    logic [7:0] r_ack_tmo;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= iebam_pkg::DEV_ADDR_RST;
            r_ack_tmo  <= iebam_pkg::ACK_TMO_RST;
        end else if (wr_en) begin
            if (paddr[2] == iebam_pkg::REG_DEV_ADDR) begin
                r_dev_addr <= pwdata[6:0];
            end else begin
                r_ack_tmo <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == iebam_pkg::REG_ACK_TMO) begin
            prdata = {24'd0, r_ack_tmo};
        end else begin
            prdata = {25'd0, r_dev_addr};
        end
    end

    assign o_cfg.device_address = r_dev_addr;
    assign o_cfg.ack_timeout    = r_ack_tmo;

endmodule

/* rtl/iebam_step.sv */
// Next-state and line-level logic for one bus phase tick.
module iebam_step (
    input  iebam_pkg::t_state   i_cur,
    input  iebam_pkg::t_cfg     i_cfg,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_word_address,
    input  logic [7:0]          i_write_data,
    input  logic                i_sda_in,
    output iebam_pkg::t_state   o_nxt,
    output iebam_pkg::t_result  o_res
);

    always_comb begin
        iebam_pkg::t_state s;
        iebam_pkg::t_stage succ;
        logic [7:0]        ctrl;
        logic [7:0]        wbyte;
        logic [3:0]        bc_inc;
        logic              busy;
        logic              done;

        s    = i_cur;
        busy = 1'b0;
        done = 1'b0;

        if (i_cur.stage == iebam_pkg::ST_IDLE && i_cur.sub == 2'd0 &&
            (i_action == iebam_pkg::ACT_WRITE || i_action == iebam_pkg::ACT_READ)) begin
            s.is_read      = (i_action == iebam_pkg::ACT_READ);
            s.held_address = i_word_address;
            s.held_data    = i_write_data;
            s.bit_count    = 4'd0;
            s.poll_count   = 9'd0;
            s.stage        = iebam_pkg::ST_START1;
            s.sub          = 2'd0;
        end

        ctrl   = {i_cfg.device_address, 1'b0};
        bc_inc = s.bit_count + 4'd1;

        case (s.stage)
            iebam_pkg::ST_ADDR:  wbyte = s.held_address;
            iebam_pkg::ST_DATA:  wbyte = s.held_data;
            iebam_pkg::ST_CTRLR: wbyte = ctrl | 8'h01;
            default:             wbyte = ctrl;
        endcase

        case (s.stage)
            iebam_pkg::ST_START1: succ = iebam_pkg::ST_CTRLW;
            iebam_pkg::ST_START2: succ = iebam_pkg::ST_CTRLR;
            iebam_pkg::ST_CTRLW:  succ = iebam_pkg::ST_ACK1;
            iebam_pkg::ST_ACK1:   succ = iebam_pkg::ST_ADDR;
            iebam_pkg::ST_ADDR:   succ = iebam_pkg::ST_ACK2;
            iebam_pkg::ST_ACK2:   succ = s.is_read ? iebam_pkg::ST_START2
                                                   : iebam_pkg::ST_DATA;
            iebam_pkg::ST_DATA:   succ = iebam_pkg::ST_ACK3;
            iebam_pkg::ST_ACK3:   succ = iebam_pkg::ST_STOP;
            iebam_pkg::ST_CTRLR:  succ = iebam_pkg::ST_ACK4;
            iebam_pkg::ST_ACK4:   succ = iebam_pkg::ST_READ;
            iebam_pkg::ST_READ:   succ = iebam_pkg::ST_STOP;
            default:              succ = iebam_pkg::ST_IDLE;
        endcase

        case (s.stage)
            iebam_pkg::ST_START1, iebam_pkg::ST_START2: begin
                busy = 1'b1;
                case (s.sub)
                    2'd0: begin s.sda = 1'b1; s.sub = 2'd1; end
                    2'd1: begin s.scl = 1'b1; s.sub = 2'd2; end
                    2'd2: begin s.sda = 1'b0; s.sub = 2'd3; end
                    default: begin
                        s.scl   = 1'b0;
                        s.stage = succ;
                        s.sub   = 2'd0;
                    end
                endcase
            end
            iebam_pkg::ST_CTRLW, iebam_pkg::ST_ADDR, iebam_pkg::ST_DATA,
            iebam_pkg::ST_CTRLR: begin
                busy = 1'b1;
                case (s.sub)
                    2'd0: begin
                        s.sda = wbyte[3'd7 - s.bit_count[2:0]];
                        s.sub = 2'd1;
                    end
                    2'd1: begin s.scl = 1'b1; s.sub = 2'd2; end
                    2'd2: begin
                        s.scl       = 1'b0;
                        s.bit_count = bc_inc;
                        s.sub       = bc_inc[3] ? 2'd3 : 2'd0;
                    end
                    default: begin
                        s.sda       = 1'b1;
                        s.scl       = 1'b0;
                        s.bit_count = 4'd0;
                        s.stage     = succ;
                        s.sub       = 2'd0;
                    end
                endcase
            end
            iebam_pkg::ST_ACK1, iebam_pkg::ST_ACK2, iebam_pkg::ST_ACK3,
            iebam_pkg::ST_ACK4: begin
                busy = 1'b1;
                if (s.sub == 2'd0) begin
                    s.scl        = 1'b1;
                    s.poll_count = 9'd0;
                    s.sub        = 2'd1;
                end else if (!i_sda_in ||
                             s.poll_count >= {1'b0, i_cfg.ack_timeout}) begin
                    // missing ACK after timeout is not reported
                    s.scl   = 1'b0;
                    s.stage = succ;
                    s.sub   = 2'd0;
                end else begin
                    s.poll_count = s.poll_count + 9'd1;
                end
            end
            iebam_pkg::ST_READ: begin
                busy = 1'b1;
                case (s.sub)
                    2'd0: begin
                        s.sda       = 1'b1;
                        s.bit_count = 4'd0;
                        s.sub       = 2'd1;
                    end
                    2'd1: begin
                        s.scl        = 1'b1;
                        s.shift_byte = {s.shift_byte[6:0], i_sda_in};
                        s.sub        = 2'd2;
                    end
                    2'd2: begin
                        s.scl       = 1'b0;
                        s.bit_count = bc_inc;
                        s.sub       = bc_inc[3] ? 2'd3 : 2'd1;
                    end
                    default: begin
                        s.sda       = 1'b1;
                        s.scl       = 1'b0;
                        s.bit_count = 4'd0;
                        s.stage     = succ;
                        s.sub       = 2'd0;
                    end
                endcase
            end
            iebam_pkg::ST_STOP: begin
                busy = 1'b1;
                case (s.sub)
                    2'd0: begin s.sda = 1'b0; s.sub = 2'd1; end
                    2'd1: begin s.scl = 1'b1; s.sub = 2'd2; end
                    default: begin
                        s.sda   = 1'b1;
                        s.stage = iebam_pkg::ST_IDLE;
                        s.sub   = 2'd0;
                        done    = 1'b1;
                    end
                endcase
            end
            default: begin
                s.stage = iebam_pkg::ST_IDLE;
                s.sub   = 2'd0;
            end
        endcase

        o_nxt           = s;
        o_res.scl_out   = s.scl;
        o_res.sda_out   = s.sda;
        o_res.busy_res  = busy;
        o_res.done_res  = done;
        o_res.read_data = s.shift_byte;
    end

endmodule

/* rtl/i2c_eeprom_byte_access_master.sv */
// Top level: I2C EEPROM byte write / random read master, one bus tick per word.
// Latency: the result word for an input word is valid the cycle after it is accepted.
// One word per cycle unless stalled; the sequencer state and result register both
// update at input accept, so a new word is taken while the previous result drains.
// Reset: synchronous active-low; sequencer idle, both lines released, registers
// return to device address 80 and ACK timeout 255, output register empty.
module i2c_eeprom_byte_access_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_word_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    iebam_pkg::t_cfg    cfg;
    iebam_pkg::t_state  r_state;
    iebam_pkg::t_state  n_state;
    iebam_pkg::t_result r_res;
    iebam_pkg::t_result n_res;
    logic               r_out_valid;
    logic               in_acc;

    iebam_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    iebam_step u_step (
        .i_cur          (r_state),
        .i_cfg          (cfg),
        .i_action       (i_action),
        .i_word_address (i_word_address),
        .i_write_data   (i_write_data),
        .i_sda_in       (i_sda_in),
        .o_nxt          (n_state),
        .o_res          (n_res)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.stage        <= iebam_pkg::ST_IDLE;
            r_state.sub          <= 2'd0;
            r_state.bit_count    <= 4'd0;
            r_state.shift_byte   <= 8'd0;
            r_state.poll_count   <= 9'd0;
            r_state.is_read      <= 1'b0;
            r_state.held_address <= 8'd0;
            r_state.held_data    <= 8'd0;
            r_state.scl          <= 1'b1;
            r_state.sda          <= 1'b1;
            r_out_valid          <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_res.scl_out;
    assign o_sda_out   = r_res.sda_out;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_read_data = r_res.read_data;

    // idle sequencer always leaves both lines released
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stage == iebam_pkg::ST_IDLE) |-> (r_state.scl && r_state.sda))
        else $error("idle with a line driven low");

    // a command taken while idle starts a sequence on that tick
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.stage == iebam_pkg::ST_IDLE &&
         (i_action == iebam_pkg::ACT_WRITE || i_action == iebam_pkg::ACT_READ))
        |=> (r_out_valid && r_res.busy_res &&
             r_state.stage == iebam_pkg::ST_START1))
        else $error("command not started");

    // stop completion returns the sequencer to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_res.done_res) |=> (r_state.stage == iebam_pkg::ST_IDLE))
        else $error("done without return to idle");

    // sequencer state only moves on accepted words
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_state))
        else $error("state changed without an accepted word");

endmodule
